/* src/bgld_pkg.sv */
// bgld_pkg: constants, phase and code values, crc and kind helpers for the deframer
// no dependencies

package bgld_pkg;

  localparam int unsigned HDR_BYTES = 28;

  localparam logic [7:0]  SYNC0    = 8'hAA;
  localparam logic [7:0]  SYNC1    = 8'h44;
  localparam logic [7:0]  SYNC2    = 8'h12;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd992;

  localparam logic [2:0] PH_HUNT0 = 3'd0;
  localparam logic [2:0] PH_HUNT1 = 3'd1;
  localparam logic [2:0] PH_HUNT2 = 3'd2;
  localparam logic [2:0] PH_HEAD  = 3'd3;
  localparam logic [2:0] PH_BODY  = 3'd4;
  localparam logic [2:0] PH_TAIL  = 3'd5;

  localparam logic [2:0] KIND_EPHEM = 3'd0;
  localparam logic [2:0] KIND_IONO  = 3'd1;
  localparam logic [2:0] KIND_OBS   = 3'd2;
  localparam logic [2:0] KIND_POS   = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;

  localparam logic [1:0] ST_CRC_GOOD = 2'd0;
  localparam logic [1:0] ST_CRC_BAD  = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  localparam logic [15:0] ID_EPHEM = 16'd7;
  localparam logic [15:0] ID_IONO  = 16'd8;
  localparam logic [15:0] ID_OBS_A = 16'd43;
  localparam logic [15:0] ID_OBS_B = 16'd140;
  localparam logic [15:0] ID_POS   = 16'd47;

  // byte-wide reflected crc-32 update
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] kind_of(input logic [15:0] id);
    logic [2:0] k;
    if (id == ID_EPHEM) begin
      k = KIND_EPHEM;
    end else if (id == ID_IONO) begin
      k = KIND_IONO;
    end else if (id == ID_OBS_A || id == ID_OBS_B) begin
      k = KIND_OBS;
    end else if (id == ID_POS) begin
      k = KIND_POS;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

  localparam logic [31:0] CRC_SYNC = crc_byte(crc_byte(crc_byte(32'd0, SYNC0), SYNC1), SYNC2);

endpackage

/* src/bgld_ifs.sv */
// bgld interfaces: byte stream, frame result and configuration write channels
// no dependencies

interface bgld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface bgld_frame_if;
  logic        valid;
  logic        ready;
  logic [15:0] message_id;
  logic [15:0] payload_length;
  logic [15:0] gps_week;
  logic [31:0] week_ms;
  logic [2:0]  kind;
  logic [1:0]  status;
  modport source (output valid, output message_id, output payload_length, output gps_week,
                  output week_ms, output kind, output status, input ready);
  modport sink (input valid, input message_id, input payload_length, input gps_week,
                input week_ms, input kind, input status, output ready);
endinterface

interface bgld_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_payload;
  modport source (output valid, output max_payload, input ready);
  modport sink (input valid, input max_payload, output ready);
endinterface

/* src/binary_gnss_log_deframer.sv */
// binary_gnss_log_deframer: sync hunt, header capture, crc-32 check, one result per frame
// depends on bgld_pkg and the interfaces in bgld_ifs.sv
// result: registered, valid in the cycle after the beat holding the last crc byte
//   (or the last header byte when the length is oversize)
// throughput: one byte per cycle; input stalls only on the last header byte or the last
//   crc byte of a frame while the result register is still full
// reset (synchronous, active high): hunt for first sync byte, max_payload 992, no result

module binary_gnss_log_deframer
  import bgld_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  bgld_byte_if.sink    byte_in,
  bgld_cfg_if.sink     cfg,
  bgld_frame_if.source frame_out
);

  logic [15:0] max_payload;
  logic [2:0]  phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [31:0] running_crc, running_crc_next;
  logic [15:0] held_id, held_id_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] held_week, held_week_next;
  logic [31:0] held_ms, held_ms_next;
  logic [31:0] received_crc, received_crc_next;
  logic        out_valid;
  logic        emit;
  logic [1:0]  emit_status;
  logic        end_slot;
  logic        in_fire;
  logic [7:0]  b;
  logic [15:0] cnt_inc;
  logic [31:0] crc_upd;

  assign b        = byte_in.data_byte;
  assign cnt_inc  = byte_count + 16'd1;
  assign crc_upd  = crc_byte(running_crc, b);
  assign end_slot = (phase == PH_HEAD && byte_count == 16'(HDR_BYTES - 1)) ||
                    (phase == PH_TAIL && byte_count == 16'd3);

  assign byte_in.ready = !(out_valid && !frame_out.ready && end_slot);
  assign in_fire       = byte_in.valid && byte_in.ready;
  assign cfg.ready     = 1'b1;

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    running_crc_next  = running_crc;
    held_id_next      = held_id;
    held_length_next  = held_length;
    held_week_next    = held_week;
    held_ms_next      = held_ms;
    received_crc_next = received_crc;
    emit              = 1'b0;
    emit_status       = ST_CRC_GOOD;
    case (phase)
      PH_HUNT0: begin
        phase_next = (b == SYNC0) ? PH_HUNT1 : PH_HUNT0;
      end
      PH_HUNT1: begin
        if (b == SYNC1) begin
          phase_next = PH_HUNT2;
        end else begin
          phase_next = (b == SYNC0) ? PH_HUNT1 : PH_HUNT0;
        end
      end
      PH_HUNT2: begin
        if (b == SYNC2) begin
          running_crc_next  = CRC_SYNC;
          held_id_next      = '0;
          held_length_next  = '0;
          held_week_next    = '0;
          held_ms_next      = '0;
          received_crc_next = '0;
          byte_count_next   = 16'd3;
          phase_next        = PH_HEAD;
        end else begin
          phase_next = (b == SYNC0) ? PH_HUNT1 : PH_HUNT0;
        end
      end
      PH_HEAD: begin
        running_crc_next = crc_upd;
        case (byte_count)
          16'd4:   held_id_next[7:0]      = b;
          16'd5:   held_id_next[15:8]     = b;
          16'd8:   held_length_next[7:0]  = b;
          16'd9:   held_length_next[15:8] = b;
          16'd14:  held_week_next[7:0]    = b;
          16'd15:  held_week_next[15:8]   = b;
          16'd16:  held_ms_next[7:0]      = b;
          16'd17:  held_ms_next[15:8]     = b;
          16'd18:  held_ms_next[23:16]    = b;
          16'd19:  held_ms_next[31:24]    = b;
          default: ;
        endcase
        byte_count_next = cnt_inc;
        if (cnt_inc >= 16'(HDR_BYTES)) begin
          byte_count_next = '0;
          if (held_length_next > max_payload) begin
            emit        = 1'b1;
            emit_status = ST_OVERSIZE;
            phase_next  = PH_HUNT0;
          end else begin
            phase_next = (held_length_next == 16'd0) ? PH_TAIL : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        running_crc_next = crc_upd;
        byte_count_next  = cnt_inc;
        if (cnt_inc >= held_length) begin
          byte_count_next = '0;
          phase_next      = PH_TAIL;
        end
      end
      PH_TAIL: begin
        received_crc_next = received_crc | (32'(b) << {byte_count[1:0], 3'b000});
        byte_count_next   = cnt_inc;
        if (cnt_inc >= 16'd4) begin
          emit            = 1'b1;
          emit_status     = (received_crc_next == running_crc) ? ST_CRC_GOOD : ST_CRC_BAD;
          phase_next      = PH_HUNT0;
          byte_count_next = '0;
        end
      end
      default: begin
        phase_next = PH_HUNT0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload  <= MAX_PAYLOAD_RESET;
      phase        <= PH_HUNT0;
      byte_count   <= '0;
      running_crc  <= '0;
      held_id      <= '0;
      held_length  <= '0;
      held_week    <= '0;
      held_ms      <= '0;
      received_crc <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        max_payload <= cfg.max_payload;
      end
      if (in_fire) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        running_crc  <= running_crc_next;
        held_id      <= held_id_next;
        held_length  <= held_length_next;
        held_week    <= held_week_next;
        held_ms      <= held_ms_next;
        received_crc <= received_crc_next;
      end
      if (in_fire && emit) begin
        out_valid <= 1'b1;
      end else if (frame_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      frame_out.message_id     <= held_id_next;
      frame_out.payload_length <= held_length_next;
      frame_out.gps_week       <= held_week_next;
      frame_out.week_ms        <= held_ms_next;
      frame_out.kind           <= kind_of(held_id_next);
      frame_out.status         <= emit_status;
    end
  end

  assign frame_out.valid = out_valid;

endmodule

/* src/bgld_checker.sv */
// bgld_port_checks: port-level checks on the deframer result and input channels
// bound to binary_gnss_log_deframer; depends on bgld_pkg

module bgld_port_checks
  import bgld_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] message_id,
  input logic [2:0]  kind,
  input logic [1:0]  status,
  input logic [15:0] payload_length
);

  // a stalled result beat stays
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(message_id) && $stable(payload_length) &&
                                $stable(status) && $stable(kind))
    else $error("result payload changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_CRC_GOOD || status == ST_CRC_BAD || status == ST_OVERSIZE)
    else $error("undefined status code");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_OTHER) == !(message_id == ID_EPHEM || message_id == ID_IONO ||
                  message_id == ID_OBS_A || message_id == ID_OBS_B || message_id == ID_POS))
    else $error("kind does not match message id");

  // input back-pressure only comes from a full, stalled result register
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

endmodule

bind binary_gnss_log_deframer bgld_port_checks u_bgld_port_checks (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (byte_in.ready),
  .out_valid      (frame_out.valid),
  .out_ready      (frame_out.ready),
  .message_id     (frame_out.message_id),
  .kind           (frame_out.kind),
  .status         (frame_out.status),
  .payload_length (frame_out.payload_length)
);

/* dv/bgld_checker.sv */
// bgld_checker: predicts the deframer's frame results from the byte and configuration beats
// and compares every result beat with the oldest prediction, field by field
// depends on bgld_pkg and the interfaces in bgld_ifs.sv

module bgld_checker
  import bgld_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  bgld_byte_if  byte_ch,
  bgld_cfg_if   cfg_ch,
  bgld_frame_if frame_ch,
  output int    fail_count,
  output int    waiting,
  output logic  hunting
);

  typedef struct packed {
    logic [15:0] message_id;
    logic [15:0] payload_length;
    logic [15:0] gps_week;
    logic [31:0] week_ms;
    logic [2:0]  kind;
    logic [1:0]  status;
  } frame_rec_t;

  frame_rec_t  pending_frames[$];
  logic [15:0] max_len;
  logic [2:0]  phase;
  logic [15:0] pos;
  logic [31:0] crc_acc;
  logic [31:0] tail_crc;
  logic [15:0] hdr_id;
  logic [15:0] hdr_len;
  logic [15:0] hdr_week;
  logic [31:0] hdr_ms;
  int          fails = 0;

  function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc ^ {24'd0, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [2:0] class_of(input logic [15:0] id);
    case (id)
      ID_EPHEM:           return KIND_EPHEM;
      ID_IONO:            return KIND_IONO;
      ID_OBS_A, ID_OBS_B: return KIND_OBS;
      ID_POS:             return KIND_POS;
      default:            return KIND_OTHER;
    endcase
  endfunction

  function automatic int field_bad(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic close_frame(input logic [1:0] st);
    frame_rec_t rec;
    rec.message_id     = hdr_id;
    rec.payload_length = hdr_len;
    rec.gps_week       = hdr_week;
    rec.week_ms        = hdr_ms;
    rec.kind           = class_of(hdr_id);
    rec.status         = st;
    pending_frames.push_back(rec);
    phase = PH_HUNT0;
    pos   = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    case (phase)
      PH_HUNT0: begin
        phase = (b == SYNC0) ? PH_HUNT1 : PH_HUNT0;
      end
      PH_HUNT1: begin
        phase = (b == SYNC1) ? PH_HUNT2 : ((b == SYNC0) ? PH_HUNT1 : PH_HUNT0);
      end
      PH_HUNT2: begin
        if (b == SYNC2) begin
          crc_acc  = crc_step(crc_step(crc_step(32'd0, SYNC0), SYNC1), SYNC2);
          hdr_id   = '0;
          hdr_len  = '0;
          hdr_week = '0;
          hdr_ms   = '0;
          tail_crc = '0;
          pos      = 16'd3;
          phase    = PH_HEAD;
        end else begin
          phase = (b == SYNC0) ? PH_HUNT1 : PH_HUNT0;
        end
      end
      PH_HEAD: begin
        crc_acc = crc_step(crc_acc, b);
        case (pos)
          4:  hdr_id[7:0]    = b;
          5:  hdr_id[15:8]   = b;
          8:  hdr_len[7:0]   = b;
          9:  hdr_len[15:8]  = b;
          14: hdr_week[7:0]  = b;
          15: hdr_week[15:8] = b;
          16: hdr_ms[7:0]    = b;
          17: hdr_ms[15:8]   = b;
          18: hdr_ms[23:16]  = b;
          19: hdr_ms[31:24]  = b;
          default: ;
        endcase
        pos = pos + 16'd1;
        if (pos >= HDR_BYTES) begin
          pos = '0;
          if (hdr_len > max_len) begin
            close_frame(ST_OVERSIZE);
          end else begin
            phase = (hdr_len == 16'd0) ? PH_TAIL : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        crc_acc = crc_step(crc_acc, b);
        pos = pos + 16'd1;
        if (pos >= hdr_len) begin
          pos   = '0;
          phase = PH_TAIL;
        end
      end
      PH_TAIL: begin
        tail_crc[8 * pos[1:0] +: 8] = b;
        pos = pos + 16'd1;
        if (pos >= 16'd4) begin
          close_frame((tail_crc == crc_acc) ? ST_CRC_GOOD : ST_CRC_BAD);
        end
      end
      default: begin
        phase = PH_HUNT0;
      end
    endcase
  endtask

  always @(posedge clk) begin
    frame_rec_t want;
    if (rst) begin
      max_len  = MAX_PAYLOAD_RESET;
      phase    = PH_HUNT0;
      pos      = '0;
      crc_acc  = '0;
      tail_crc = '0;
      hdr_id   = '0;
      hdr_len  = '0;
      hdr_week = '0;
      hdr_ms   = '0;
      pending_frames.delete();
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        if (pending_frames.size() == 0) begin
          $error("frame beat with nothing expected: message_id %0h, status %0d",
                 frame_ch.message_id, frame_ch.status);
          fails++;
        end else begin
          want = pending_frames.pop_front();
          fails += field_bad("message_id", want.message_id, frame_ch.message_id);
          fails += field_bad("payload_length", want.payload_length, frame_ch.payload_length);
          fails += field_bad("gps_week", want.gps_week, frame_ch.gps_week);
          fails += field_bad("week_ms", want.week_ms, frame_ch.week_ms);
          fails += field_bad("kind", want.kind, frame_ch.kind);
          fails += field_bad("status", want.status, frame_ch.status);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        max_len = cfg_ch.max_payload;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        take_byte(byte_ch.data_byte);
      end
    end
    fail_count <= fails;
    waiting    <= pending_frames.size();
    hunting    <= (phase == PH_HUNT0) || (phase == PH_HUNT1) || (phase == PH_HUNT2);
  end

endmodule

/* dv/tb_top.sv */
// tb_top: clock, reset, byte stream and configuration stimulus for binary_gnss_log_deframer,
// random stalls on the frame channel and the final verdict
// depends on bgld_pkg, bgld_ifs.sv, the deframer and dv/bgld_checker.sv

module tb_top;
  import bgld_pkg::*;

  logic clk;
  logic rst;
  int   chk_fails;
  int   chk_waiting;
  logic chk_hunting;

  int          burst_left  = 0;
  bit          driving     = 1'b0;
  logic [15:0] cur_max     = MAX_PAYLOAD_RESET;
  int          frames_done = 0;
  int          frame_bytes = 0;

  bgld_byte_if  byte_ch ();
  bgld_cfg_if   cfg_ch ();
  bgld_frame_if frame_ch ();

  binary_gnss_log_deframer DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .cfg       (cfg_ch),
    .frame_out (frame_ch)
  );

  bgld_checker chk (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .cfg_ch     (cfg_ch),
    .frame_ch   (frame_ch),
    .fail_count (chk_fails),
    .waiting    (chk_waiting),
    .hunting    (chk_hunting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side stalls in spans of its own
  initial begin
    int mode;
    int span;
    frame_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       frame_ch.ready <= 1'b1;
          1:       frame_ch.ready <= 1'($urandom_range(0, 1));
          default: frame_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      if (driving) begin
        byte_ch.valid <= 1'b0;
      end
      driving = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3))
        @(posedge clk);
      burst_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(16, 200);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    driving = 1'b1;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic pause_stream();
    if (driving) begin
      byte_ch.valid <= 1'b0;
    end
    driving    = 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_results();
    pause_stream();
    @(negedge clk);
    while (chk_waiting != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // drain any frame in progress with filler beats, then let the last result out
  task automatic settle();
    do send_byte(8'h00); while (!chk_hunting);
    wait_results();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.max_payload <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_max = v;
  endtask

  // a cut above zero and below the frame's length stops the frame after that many beats
  task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                            input logic [15:0] week, input logic [31:0] ms,
                            input bit bad_crc, input int cut);
    logic [7:0]  hdr[HDR_BYTES];
    logic [31:0] crc;
    logic [7:0]  b;
    int          total;
    int          k;
    int          flip_at;
    for (int i = 0; i < HDR_BYTES; i++) hdr[i] = 8'($urandom);
    hdr[0]  = SYNC0;
    hdr[1]  = SYNC1;
    hdr[2]  = SYNC2;
    hdr[4]  = id[7:0];
    hdr[5]  = id[15:8];
    hdr[8]  = len[7:0];
    hdr[9]  = len[15:8];
    hdr[14] = week[7:0];
    hdr[15] = week[15:8];
    hdr[16] = ms[7:0];
    hdr[17] = ms[15:8];
    hdr[18] = ms[23:16];
    hdr[19] = ms[31:24];
    crc     = 32'd0;
    flip_at = $urandom_range(0, 3);
    total   = int'(HDR_BYTES) + ((len > cur_max) ? 0 : int'(len) + 4);
    if (cut > 0 && cut < total) begin
      total = cut;
    end else begin
      frames_done++;
    end
    frame_bytes += total;
    for (int n = 0; n < total; n++) begin
      k = n - int'(HDR_BYTES) - int'(len);
      if (n < HDR_BYTES) begin
        b = hdr[n];
      end else if (k < 0) begin
        b = 8'($urandom);
      end else begin
        b = crc[8 * k +: 8];
        if (bad_crc && k == flip_at) begin
          b = b ^ (8'd1 << $urandom_range(0, 7));
        end
      end
      if (k < 0) begin
        crc = crc_byte(crc, b);
      end
      send_byte(b);
    end
  endtask

  initial begin
    logic [15:0] id;
    logic [15:0] len;
    logic [15:0] new_max;
    logic [7:0]  nb;
    int          pick;
    int          cut;
    int          items;
    rst                = 1'b1;
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = 8'h00;
    cfg_ch.valid       = 1'b0;
    cfg_ch.max_payload = 16'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: every kind, field extremes, sync restarts, crc and length edges
    send_frame(ID_EPHEM, 16'd0, 16'd0, 32'd0, 1'b0, 0);
    send_frame(ID_IONO, 16'd1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 0);
    send_byte(SYNC0);
    send_byte(SYNC1);
    send_frame(ID_OBS_A, 16'd7, 16'($urandom), $urandom, 1'b0, 0);
    send_byte(SYNC0);
    send_frame(ID_OBS_B, 16'd3, 16'($urandom), $urandom, 1'b0, 0);
    send_byte(SYNC0);
    send_byte(SYNC1);
    send_byte(8'h13);
    send_byte(SYNC2);
    send_frame(ID_POS, 16'd12, 16'($urandom), $urandom, 1'b0, 0);
    send_frame(16'd0, 16'd2, 16'($urandom), $urandom, 1'b1, 0);
    send_frame(16'hFFFF, 16'd0, 16'($urandom), $urandom, 1'b1, 0);
    send_frame(ID_OBS_A, 16'd24, 16'($urandom), $urandom, 1'b0, 0);
    send_frame(ID_POS, MAX_PAYLOAD_RESET + 16'd1, 16'($urandom), $urandom, 1'b0, 0);
    send_frame(16'd1234, 16'hFFFF, 16'($urandom), $urandom, 1'b0, 0);
    settle();
    write_max(16'd0);
    send_frame(ID_EPHEM, 16'd0, 16'($urandom), $urandom, 1'b0, 0);
    send_frame(ID_IONO, 16'd0, 16'($urandom), $urandom, 1'b1, 0);
    send_frame(ID_OBS_B, 16'd1, 16'($urandom), $urandom, 1'b0, 0);
    settle();
    write_max(16'hFFFF);
    send_frame(ID_OBS_B, 16'd48, 16'($urandom), $urandom, 1'b0, 0);
    send_frame(ID_POS, 16'd40, 16'($urandom), $urandom, 1'b1, 0);
    settle();
    write_max(16'd1);
    send_frame(ID_EPHEM, 16'd1, 16'($urandom), $urandom, 1'b0, 0);
    send_frame(ID_IONO, 16'd2, 16'($urandom), $urandom, 1'b0, 0);
    settle();

    // random: phases of one limit each, mostly well-formed frames
    items = 0;
    while (frame_bytes < 1700 || frames_done < 30) begin
      case ($urandom_range(0, 5))
        0:       new_max = 16'd0;
        1:       new_max = 16'hFFFF;
        2:       new_max = MAX_PAYLOAD_RESET;
        3:       new_max = 16'($urandom_range(0, 40));
        4:       new_max = 16'($urandom_range(41, 400));
        default: new_max = 16'($urandom);
      endcase
      write_max(new_max);
      repeat ($urandom_range(6, 12)) begin
        if ($urandom_range(0, 9) < 3) begin
          case ($urandom_range(0, 4))
            0: send_byte(SYNC0);
            1: begin
              send_byte(SYNC0);
              send_byte(SYNC1);
            end
            2: begin
              nb = 8'($urandom);
              if (nb == SYNC2) nb = 8'h13;
              send_byte(SYNC0);
              send_byte(SYNC1);
              send_byte(nb);
            end
            3: begin
              send_byte(SYNC1);
              send_byte(SYNC2);
            end
            default: send_byte(8'($urandom));
          endcase
        end
        case ($urandom_range(0, 7))
          0:       id = ID_EPHEM;
          1:       id = ID_IONO;
          2:       id = ID_OBS_A;
          3:       id = ID_OBS_B;
          4:       id = ID_POS;
          5:       id = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
          default: id = 16'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 15 && cur_max < 16'hFFFF) begin
          len = 16'($urandom_range(int'(cur_max) + 1, 65535));
        end else if (pick < 60) begin
          len = 16'($urandom_range(0, (cur_max < 16'd24) ? int'(cur_max) : 24));
        end else if (pick < 80) begin
          len = 16'($urandom_range(0, (cur_max < 16'd200) ? int'(cur_max) : 200));
        end else begin
          len = (cur_max <= 16'd300) ? cur_max : 16'($urandom_range(0, 24));
        end
        cut = (cur_max <= 16'd1024 && $urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 0;
        send_frame(id, len, 16'($urandom), $urandom, ($urandom_range(0, 6) == 0), cut);
        items++;
        if (items % 25 == 0) begin
          wait_results();
        end
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (chk_fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
